/* src/ahs_pkg.sv */
// Shared types, constants and microcode ROM for the allreduce halving schedule unit.
`default_nettype none
package ahs_pkg;

    localparam int MAX_STEPS = 10;
    localparam int CNT_W     = 31;
    localparam int RANK_W    = 11;
    localparam int STEP_W    = 4;
    localparam int UPC_W     = 4;
    localparam int EMIT_W    = 4;

    // register indexes
    localparam logic REG_NRANKS   = 1'b0;
    localparam logic REG_OWN_RANK = 1'b1;

    // phase codes
    localparam logic [1:0] PH_PRE  = 2'd0;
    localparam logic [1:0] PH_RS   = 2'd1;
    localparam logic [1:0] PH_AG   = 2'd2;
    localparam logic [1:0] PH_HAND = 2'd3;

    // microcode addresses
    localparam logic [UPC_W-1:0] UA_IDLE   = 4'd0;
    localparam logic [UPC_W-1:0] UA_REJECT = 4'd1;
    localparam logic [UPC_W-1:0] UA_PSWAP  = 4'd2;
    localparam logic [UPC_W-1:0] UA_PRET   = 4'd3;
    localparam logic [UPC_W-1:0] UA_XSWAP  = 4'd4;
    localparam logic [UPC_W-1:0] UA_XRET   = 4'd5;
    localparam logic [UPC_W-1:0] UA_XHAND  = 4'd6;
    localparam logic [UPC_W-1:0] UA_RS     = 4'd7;
    localparam logic [UPC_W-1:0] UA_AG     = 4'd8;
    localparam logic [UPC_W-1:0] UA_PHAND  = 4'd9;

    // emit codes
    localparam logic [EMIT_W-1:0] EM_NONE       = 4'd0;
    localparam logic [EMIT_W-1:0] EM_REJECT     = 4'd1;
    localparam logic [EMIT_W-1:0] EM_PROXY_SWAP = 4'd2;
    localparam logic [EMIT_W-1:0] EM_PROXY_RET  = 4'd3;
    localparam logic [EMIT_W-1:0] EM_EXTRA_SWAP = 4'd4;
    localparam logic [EMIT_W-1:0] EM_EXTRA_RET  = 4'd5;
    localparam logic [EMIT_W-1:0] EM_EXTRA_HAND = 4'd6;
    localparam logic [EMIT_W-1:0] EM_PROXY_HAND = 4'd7;
    localparam logic [EMIT_W-1:0] EM_RS         = 4'd8;
    localparam logic [EMIT_W-1:0] EM_AG         = 4'd9;

    // branch codes
    localparam logic [2:0] BR_NEXT     = 3'd0;
    localparam logic [2:0] BR_GOTO     = 3'd1;
    localparam logic [2:0] BR_DISPATCH = 3'd2;
    localparam logic [2:0] BR_RS_LOOP  = 3'd3;
    localparam logic [2:0] BR_AG_LOOP  = 3'd4;

    // last-flag modes
    localparam logic [1:0] LM_NO     = 2'd0;
    localparam logic [1:0] LM_YES    = 2'd1;
    localparam logic [1:0] LM_AG_END = 2'd2;

    typedef struct packed {
        logic [EMIT_W-1:0] emit;
        logic [2:0]        br;
        logic [UPC_W-1:0]  target;
        logic [1:0]        last_mode;
    } ctrl_word_t;

    typedef struct packed {
        logic [EMIT_W-1:0] emit;
        logic              last;
        logic [STEP_W-1:0] step;
        logic [STEP_W-1:0] step_next;
    } seq_ctrl_t;

    typedef struct packed {
        logic [STEP_W-1:0] nstep;
        logic [RANK_W-1:0] rem;
        logic [RANK_W-1:0] vrank;
        logic              proxy;
        logic              extra;
    } cfg_info_t;

    typedef struct packed {
        logic [CNT_W-1:0] so;
        logic [CNT_W-1:0] sl;
        logic [CNT_W-1:0] ro;
        logic [CNT_W-1:0] rl;
    } step_entry_t;

    function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] upc);
        ctrl_word_t w;
        w = '{emit: EM_NONE, br: BR_DISPATCH, target: UA_IDLE, last_mode: LM_NO};
        unique case (upc)
            UA_IDLE:   w = '{EM_NONE,       BR_DISPATCH, UA_IDLE,  LM_NO};
            UA_REJECT: w = '{EM_REJECT,     BR_GOTO,     UA_IDLE,  LM_YES};
            UA_PSWAP:  w = '{EM_PROXY_SWAP, BR_NEXT,     UA_IDLE,  LM_NO};
            UA_PRET:   w = '{EM_PROXY_RET,  BR_GOTO,     UA_RS,    LM_NO};
            UA_XSWAP:  w = '{EM_EXTRA_SWAP, BR_NEXT,     UA_IDLE,  LM_NO};
            UA_XRET:   w = '{EM_EXTRA_RET,  BR_NEXT,     UA_IDLE,  LM_NO};
            UA_XHAND:  w = '{EM_EXTRA_HAND, BR_GOTO,     UA_IDLE,  LM_YES};
            UA_RS:     w = '{EM_RS,         BR_RS_LOOP,  UA_AG,    LM_NO};
            UA_AG:     w = '{EM_AG,         BR_AG_LOOP,  UA_PHAND, LM_AG_END};
            UA_PHAND:  w = '{EM_PROXY_HAND, BR_GOTO,     UA_IDLE,  LM_YES};
            default:   w = '{EM_NONE,       BR_DISPATCH, UA_IDLE,  LM_NO};
        endcase
        return w;
    endfunction

    function automatic logic [STEP_W-1:0] floor_log2(input logic [RANK_W-1:0] v);
        logic [STEP_W-1:0] n;
        n = '0;
        for (int i = 1; i < RANK_W; i++) begin
            if (v[i])
            begin
                n = STEP_W'(i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

/* src/ahs_sequencer.sv */
// Microcode sequencer: program counter, step counter and branch logic.
`default_nettype none
module ahs_sequencer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              reject,
    input  wire ahs_pkg::cfg_info_t info,
    output logic                   busy,
    output logic                   accept,
    output ahs_pkg::seq_ctrl_t     ctrl
);
    import ahs_pkg::*;

    logic [UPC_W-1:0]  upc_reg, upc_next;
    logic [STEP_W-1:0] ctr_reg, ctr_next;
    ctrl_word_t        cw;

    assign cw     = ucode(upc_reg);
    assign busy   = (upc_reg != UA_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        upc_next = upc_reg;
        ctr_next = ctr_reg;
        unique case (cw.br)
            BR_NEXT:
            begin
                upc_next = upc_reg + UPC_W'(1);
            end
            BR_GOTO:
            begin
                upc_next = cw.target;
            end
            BR_DISPATCH:
            begin
                ctr_next = '0;
                if (start)
                begin
                    if (reject)
                        upc_next = UA_REJECT;
                    else if (info.proxy)
                        upc_next = UA_PSWAP;
                    else if (info.extra)
                        upc_next = UA_XSWAP;
                    else
                        upc_next = UA_RS;
                end
            end
            BR_RS_LOOP:
            begin
                if ((ctr_reg + STEP_W'(1)) < info.nstep)
                    ctr_next = ctr_reg + STEP_W'(1);
                else
                begin
                    upc_next = cw.target;
                    ctr_next = info.nstep - STEP_W'(1);
                end
            end
            BR_AG_LOOP:
            begin
                if (ctr_reg != '0)
                    ctr_next = ctr_reg - STEP_W'(1);
                else
                    upc_next = info.proxy ? cw.target : UA_IDLE;
            end
            default:
            begin
                upc_next = UA_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.emit      = cw.emit;
        ctrl.step      = ctr_reg;
        ctrl.step_next = ctr_next;
        unique case (cw.last_mode)
            LM_YES:    ctrl.last = 1'b1;
            LM_AG_END: ctrl.last = (ctr_reg == '0) && !info.proxy;
            default:   ctrl.last = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_IDLE;
            ctr_reg <= '0;
        end
        else
        begin
            upc_reg <= upc_next;
            ctr_reg <= ctr_next;
        end
    end

endmodule
`default_nettype wire

/* src/ahs_datapath.sv */
// Schedule datapath: window halving, peer mapping, step table and result registers.
`default_nettype none
module ahs_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [ahs_pkg::CNT_W-1:0]   element_count,
    input  wire logic [ahs_pkg::RANK_W-1:0]  own_rank,
    input  wire ahs_pkg::cfg_info_t          info,
    input  wire ahs_pkg::seq_ctrl_t          ctrl,
    output logic                             result_valid,
    output logic [1:0]                       phase,
    output logic [ahs_pkg::RANK_W-1:0]       peer_rank,
    output logic [ahs_pkg::CNT_W-1:0]        send_offset,
    output logic [ahs_pkg::CNT_W-1:0]        send_length,
    output logic [ahs_pkg::CNT_W-1:0]        recv_offset,
    output logic [ahs_pkg::CNT_W-1:0]        recv_length,
    output logic                             reduce_received,
    output logic [ahs_pkg::STEP_W-1:0]       step_number,
    output logic                             rejected,
    output logic                             last
);
    import ahs_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  win_reg, win_next;
    logic [CNT_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]  lh, rh, half, other, base_half;
    logic [RANK_W-1:0] np, peer, rank_up, rank_dn;
    logic              low_side;
    step_entry_t       rs_entry;
    step_entry_t       step_mem [MAX_STEPS];
    step_entry_t       rd_reg;

    logic              valid_reg, valid_next;
    logic [1:0]        phase_reg, phase_next;
    logic [RANK_W-1:0] peer_reg, peer_next;
    logic [CNT_W-1:0]  so_reg, so_next, sl_reg, sl_next;
    logic [CNT_W-1:0]  ro_reg, ro_next, rl_reg, rl_next;
    logic              red_reg, red_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              rej_reg, rej_next;
    logic              last_reg, last_next;

    assign lh      = count_reg >> 1;
    assign rh      = count_reg - lh;
    assign rank_up = own_rank + RANK_W'(1);
    assign rank_dn = own_rank - RANK_W'(1);

    // peer of a halving step, mapped back to the real rank
    assign np   = info.vrank ^ (RANK_W'(1) << ctrl.step);
    assign peer = (np < info.rem) ? {np[RANK_W-2:0], 1'b0} : np + info.rem;

    assign low_side  = own_rank < peer;
    assign half      = win_reg >> 1;
    assign other     = win_reg - half;
    assign base_half = base_reg + half;

    always_comb
    begin
        if (low_side)
        begin
            rs_entry.rl = half;
            rs_entry.sl = other;
            rs_entry.ro = base_reg;
            rs_entry.so = base_half;
        end
        else
        begin
            rs_entry.sl = half;
            rs_entry.rl = other;
            rs_entry.so = base_reg;
            rs_entry.ro = base_half;
        end
    end

    always_comb
    begin
        win_next  = win_reg;
        base_next = base_reg;
        if (accept)
        begin
            win_next  = element_count;
            base_next = '0;
        end
        else if (ctrl.emit == EM_RS)
        begin
            win_next  = rs_entry.rl;
            base_next = rs_entry.ro;
        end
    end

    always_comb
    begin
        valid_next = 1'b1;
        phase_next = PH_PRE;
        peer_next  = '0;
        so_next    = '0;
        sl_next    = '0;
        ro_next    = '0;
        rl_next    = '0;
        red_next   = 1'b0;
        step_next  = '0;
        rej_next   = 1'b0;
        last_next  = ctrl.last;
        unique case (ctrl.emit)
            EM_NONE:
            begin
                valid_next = 1'b0;
            end
            EM_REJECT:
            begin
                rej_next = 1'b1;
            end
            EM_PROXY_SWAP:
            begin
                peer_next = rank_up;
                so_next   = lh;
                sl_next   = rh;
                rl_next   = lh;
                red_next  = 1'b1;
            end
            EM_PROXY_RET:
            begin
                peer_next = rank_up;
                ro_next   = lh;
                rl_next   = rh;
                step_next = STEP_W'(1);
            end
            EM_EXTRA_SWAP:
            begin
                peer_next = rank_dn;
                sl_next   = lh;
                ro_next   = lh;
                rl_next   = rh;
                red_next  = 1'b1;
            end
            EM_EXTRA_RET:
            begin
                peer_next = rank_dn;
                so_next   = lh;
                sl_next   = rh;
                step_next = STEP_W'(1);
            end
            EM_EXTRA_HAND:
            begin
                phase_next = PH_HAND;
                peer_next  = rank_dn;
                rl_next    = count_reg;
            end
            EM_PROXY_HAND:
            begin
                phase_next = PH_HAND;
                peer_next  = rank_up;
                sl_next    = count_reg;
            end
            EM_RS:
            begin
                phase_next = PH_RS;
                peer_next  = peer;
                so_next    = rs_entry.so;
                sl_next    = rs_entry.sl;
                ro_next    = rs_entry.ro;
                rl_next    = rs_entry.rl;
                red_next   = 1'b1;
                step_next  = ctrl.step;
            end
            EM_AG:
            begin
                phase_next = PH_AG;
                peer_next  = peer;
                so_next    = rd_reg.ro;
                sl_next    = rd_reg.rl;
                ro_next    = rd_reg.so;
                rl_next    = rd_reg.sl;
                step_next  = ctrl.step;
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase
    end

    // step table, read one step ahead with write bypass
    always_ff @(posedge clk)
    begin
        if (ctrl.emit == EM_RS)
            step_mem[ctrl.step] <= rs_entry;
        if ((ctrl.emit == EM_RS) && (ctrl.step == ctrl.step_next))
            rd_reg <= rs_entry;
        else
            rd_reg <= step_mem[ctrl.step_next];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            count_reg <= element_count;
        win_reg   <= win_next;
        base_reg  <= base_next;
        phase_reg <= phase_next;
        peer_reg  <= peer_next;
        so_reg    <= so_next;
        sl_reg    <= sl_next;
        ro_reg    <= ro_next;
        rl_reg    <= rl_next;
        red_reg   <= red_next;
        step_reg  <= step_next;
        rej_reg   <= rej_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign result_valid    = valid_reg;
    assign phase           = phase_reg;
    assign peer_rank       = peer_reg;
    assign send_offset     = so_reg;
    assign send_length     = sl_reg;
    assign recv_offset     = ro_reg;
    assign recv_length     = rl_reg;
    assign reduce_received = red_reg;
    assign step_number     = step_reg;
    assign rejected        = rej_reg;
    assign last            = last_reg;

endmodule
`default_nettype wire

/* src/allreduce_halving_schedule_unit.sv */
// Top level: configuration registers, rank classing and sequencer/datapath hookup.
//
//   channel   signals                                   direction
//   request   start, busy, element_count, op_commutative  in (busy out)
//   result    result_valid, phase .. last                out, one cycle each
//   config    cfg_wr_en, cfg_index, cfg_wdata             in, no wait
//
// One result per cycle; the first passes through the program counter and then the result
// registers after the request is taken. Results per request: base 2*log2(P), proxy
// 2*log2(P)+3, extra 3, rejected 1; the microcode step loop sets this.
// busy is low in the cycle the last result is shown, so the next request
// can be taken then. Reset idles the sequencer and sets a group of 2, rank 0.
// Results are never held; the receiver must take each one as it appears.
`default_nettype none
module allreduce_halving_schedule_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [ahs_pkg::CNT_W-1:0]   element_count,
    input  wire logic                        op_commutative,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_index,
    input  wire logic [ahs_pkg::RANK_W-1:0]  cfg_wdata,
    output logic                             result_valid,
    output logic [1:0]                       phase,
    output logic [ahs_pkg::RANK_W-1:0]       peer_rank,
    output logic [ahs_pkg::CNT_W-1:0]        send_offset,
    output logic [ahs_pkg::CNT_W-1:0]        send_length,
    output logic [ahs_pkg::CNT_W-1:0]        recv_offset,
    output logic [ahs_pkg::CNT_W-1:0]        recv_length,
    output logic                             reduce_received,
    output logic [ahs_pkg::STEP_W-1:0]       step_number,
    output logic                             rejected,
    output logic                             last
);
    import ahs_pkg::*;

    logic [RANK_W-1:0] nranks_reg, own_rank_reg;
    cfg_info_t         info;
    seq_ctrl_t         ctrl;
    logic              reject;
    logic              accept;
    logic              in_pairs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nranks_reg   <= RANK_W'(2);
            own_rank_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_NRANKS:   nranks_reg   <= cfg_wdata;
                REG_OWN_RANK: own_rank_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    assign info.nstep = floor_log2(nranks_reg);
    assign info.rem   = nranks_reg - (RANK_W'(1) << info.nstep);
    assign in_pairs   = {1'b0, own_rank_reg} < {info.rem, 1'b0};
    assign info.proxy = in_pairs && !own_rank_reg[0];
    assign info.extra = in_pairs && own_rank_reg[0];
    assign info.vrank = info.proxy ? (own_rank_reg >> 1)
                      : info.extra ? '0
                      : own_rank_reg - info.rem;

    assign reject = (nranks_reg < RANK_W'(2))
                 || (own_rank_reg >= nranks_reg)
                 || (info.nstep > STEP_W'(MAX_STEPS))
                 || (element_count < CNT_W'(nranks_reg))
                 || !op_commutative;

    ahs_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .reject (reject),
        .info   (info),
        .busy   (busy),
        .accept (accept),
        .ctrl   (ctrl)
    );

    ahs_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .element_count   (element_count),
        .own_rank        (own_rank_reg),
        .info            (info),
        .ctrl            (ctrl),
        .result_valid    (result_valid),
        .phase           (phase),
        .peer_rank       (peer_rank),
        .send_offset     (send_offset),
        .send_length     (send_length),
        .recv_offset     (recv_offset),
        .recv_length     (recv_length),
        .reduce_received (reduce_received),
        .step_number     (step_number),
        .rejected        (rejected),
        .last            (last)
    );

endmodule
`default_nettype wire
